// ----- rtl/tav_pkg.sv -----
// Package for the 3x3 terrain aspect unit: shared types, constants and the arctangent table.
// Depends on nothing; every other file of the unit but tav_fifo imports it.
package tav_pkg;

   localparam int GRAD_W = 36;   // Horn gradient width
   localparam int CRD_W  = 39;   // CORDIC x/y width
   localparam int ANG_W  = 28;   // angle width, Q16 degrees, signed

   localparam logic [1:0] STATUS_OK   = 2'd0;
   localparam logic [1:0] STATUS_FLAT = 2'd1;
   localparam logic [1:0] STATUS_NA   = 2'd2;

   localparam logic [1:0] CSR_NUM_COLS = 2'd0;
   localparam logic [1:0] CSR_NUM_ROWS = 2'd1;
   localparam logic [1:0] CSR_NA_VALUE = 2'd2;

   localparam logic signed [ANG_W-1:0] DEG90_Q16  = 28'sd5898240;
   localparam logic signed [ANG_W-1:0] DEG180_Q16 = 28'sd11796480;
   localparam logic signed [ANG_W-1:0] DEG450_Q16 = 28'sd29491200;
   localparam logic [16:0] ASPECT_WRAP = 17'd46080;

   // Classified cell handed from the front to the back.
   typedef struct packed {
      logic [15:0]              row;
      logic [10:0]              col;
      logic                     frame_end;
      logic [1:0]               status;
      logic signed [GRAD_W-1:0] gx;
      logic signed [GRAD_W-1:0] gy;
   } cell_type;

   // Finished result.
   typedef struct packed {
      logic [15:0] row;
      logic [10:0] col;
      logic [1:0]  status;
      logic [15:0] aspect;
      logic        frame_end;
   } rsp_type;

   // atan(2^-i) in degrees, Q16.
   function automatic logic [21:0] atan_q16(input int i);
      logic [21:0] v;
      case (i)
         0: v = 22'd2949120;  1: v = 22'd1740967;  2: v = 22'd919879;  3: v = 22'd466945;
         4: v = 22'd234379;   5: v = 22'd117305;   6: v = 22'd58666;   7: v = 22'd29335;
         8: v = 22'd14668;    9: v = 22'd7334;    10: v = 22'd3667;   11: v = 22'd1833;
         12: v = 22'd917;    13: v = 22'd458;     14: v = 22'd229;    15: v = 22'd115;
         16: v = 22'd57;     17: v = 22'd29;      18: v = 22'd14;     19: v = 22'd7;
         20: v = 22'd4;      21: v = 22'd2;       22: v = 22'd1;
         default: v = 22'd0;
      endcase
      return v;
   endfunction

endpackage

// ----- rtl/tav_fifo.sv -----
// Small first-in first-out queue of fixed depth, used between and after the unit's parts.
// Depends on nothing.
module tav_fifo #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] din,
   input  logic             pop,
   output logic [WIDTH-1:0] dout,
   output logic             full,
   output logic             empty
);
   localparam int DEPTH = 4;

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [1:0]       wr_ff, wr_in, rd_ff, rd_in;
   logic [2:0]       cnt_ff, cnt_in;
   logic             do_push, do_pop;

   assign full    = (cnt_ff == 3'(DEPTH));
   assign empty   = (cnt_ff == 3'd0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign dout    = mem_ff[rd_ff];

   always_comb begin
      wr_in  = do_push ? wr_ff + 2'd1 : wr_ff;
      rd_in  = do_pop ? rd_ff + 2'd1 : rd_ff;
      cnt_in = cnt_ff + {2'b00, do_push} - {2'b00, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ff] <= din;
      end
   end
endmodule

// ----- rtl/tav_front.sv -----
// Front part: configuration, raster counters, line buffers, 3x3 window and classification.
// Depends on tav_pkg.
module tav_front import tav_pkg::*; #(
   parameter int MAX_COLS = 2048
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_we,
   input  logic [1:0]         csr_index,
   input  logic [31:0]        csr_wdata,
   input  logic               in_valid,
   input  logic signed [31:0] in_elev,
   input  logic               advance,
   output logic               out_valid,
   output cell_type           out_cell
);
   localparam int CIW = $clog2(MAX_COLS);
   localparam int CNW = $clog2(MAX_COLS + 1);

   logic [CNW-1:0]     cols_ff;
   logic [15:0]        rows_ff;
   logic signed [31:0] na_ff;
   logic [CIW-1:0]     col_ff, col_in;
   logic [15:0]        row_ff, row_in;

   logic signed [31:0] mem_a [MAX_COLS];
   logic signed [31:0] mem_b [MAX_COLS];
   logic signed [31:0] rd_a_ff, rd_b_ff;

   logic               s1v_ff, s2v_ff;
   logic signed [31:0] s1e_ff;
   logic [CIW-1:0]     s1c_ff, s2c_ff;
   logic [15:0]        s1r_ff, s2r_ff;
   logic               s1p_ff, s2p_ff, s1fe_ff, s2fe_ff;
   logic signed [31:0] win_ff [9];

   logic               accept, any_na, flat, last_col;
   logic [11:0]        wcols;
   logic signed [GRAD_W-1:0] gx, gy;

   assign accept   = in_valid && advance;
   assign wcols    = csr_wdata[11:0];
   assign last_col = (CNW'(col_ff) + CNW'(1)) >= cols_ff;

   always_comb begin
      col_in = last_col ? '0 : col_ff + CIW'(1);
      row_in = row_ff;
      if (last_col) begin
         row_in = ({1'b0, row_ff} + 17'd1 >= {1'b0, rows_ff}) ? 16'd0 : row_ff + 16'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cols_ff <= CNW'(3);
         rows_ff <= 16'd3;
         na_ff   <= 32'sh8000_0000;
         col_ff  <= '0;
         row_ff  <= '0;
         s1v_ff  <= 1'b0;
         s2v_ff  <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_NUM_COLS: begin
                  if (wcols < 12'd3) begin
                     cols_ff <= CNW'(3);
                  end else if (32'(wcols) > MAX_COLS) begin
                     cols_ff <= CNW'(MAX_COLS);
                  end else begin
                     cols_ff <= CNW'(wcols);
                  end
                  col_ff <= '0;
                  row_ff <= '0;
               end
               CSR_NUM_ROWS: begin
                  rows_ff <= (csr_wdata[15:0] < 16'd3) ? 16'd3 : csr_wdata[15:0];
                  col_ff  <= '0;
                  row_ff  <= '0;
               end
               CSR_NA_VALUE: na_ff <= csr_wdata;
               default: ;
            endcase
         end else if (accept) begin
            col_ff <= col_in;
            row_ff <= row_in;
         end
         if (advance) begin
            s1v_ff <= in_valid;
            s2v_ff <= s1v_ff;
         end
      end
   end

   // Line buffers: read on acceptance, rotate one stage later.
   always_ff @(posedge clock) begin
      if (accept) begin
         rd_a_ff <= mem_a[col_ff];
         rd_b_ff <= mem_b[col_ff];
      end
      if (advance && s1v_ff) begin
         mem_a[s1c_ff] <= s1e_ff;
         mem_b[s1c_ff] <= rd_a_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1e_ff  <= in_elev;
         s1c_ff  <= col_ff;
         s1r_ff  <= row_ff;
         s1p_ff  <= (row_ff >= 16'd2) && (CNW'(col_ff) >= CNW'(2));
         s1fe_ff <= (row_ff == rows_ff - 16'd1) && (CNW'(col_ff) == cols_ff - CNW'(1));
      end
      if (advance && s1v_ff) begin
         win_ff[0] <= win_ff[1]; win_ff[1] <= win_ff[2]; win_ff[2] <= rd_b_ff;
         win_ff[3] <= win_ff[4]; win_ff[4] <= win_ff[5]; win_ff[5] <= rd_a_ff;
         win_ff[6] <= win_ff[7]; win_ff[7] <= win_ff[8]; win_ff[8] <= s1e_ff;
         s2c_ff  <= s1c_ff;
         s2r_ff  <= s1r_ff;
         s2p_ff  <= s1p_ff;
         s2fe_ff <= s1fe_ff;
      end
   end

   always_comb begin
      any_na = 1'b0;
      flat   = 1'b1;
      for (int q = 0; q < 9; q++) begin
         if (win_ff[q] == na_ff) any_na = 1'b1;
         if (win_ff[q] != win_ff[0]) flat = 1'b0;
      end
      gx = (GRAD_W'(win_ff[2]) + (GRAD_W'(win_ff[5]) <<< 1) + GRAD_W'(win_ff[8]))
         - (GRAD_W'(win_ff[0]) + (GRAD_W'(win_ff[3]) <<< 1) + GRAD_W'(win_ff[6]));
      gy = (GRAD_W'(win_ff[6]) + (GRAD_W'(win_ff[7]) <<< 1) + GRAD_W'(win_ff[8]))
         - (GRAD_W'(win_ff[0]) + (GRAD_W'(win_ff[1]) <<< 1) + GRAD_W'(win_ff[2]));
      out_cell.row       = s2r_ff - 16'd1;
      out_cell.col       = 11'(s2c_ff - CIW'(1));
      out_cell.frame_end = s2fe_ff;
      out_cell.status    = any_na ? STATUS_NA : (flat ? STATUS_FLAT : STATUS_OK);
      out_cell.gx        = gx;
      out_cell.gy        = gy;
   end

   assign out_valid = s2v_ff && s2p_ff;
endmodule

// ----- rtl/tav_back.sv -----
// Back part: CORDIC arctangent pipeline, one rotation per stage, and compass remap.
// Depends on tav_pkg.
module tav_back import tav_pkg::*; #(
   parameter int CORDIC_STEPS = 20
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     advance,
   input  logic     in_valid,
   input  cell_type in_cell,
   output logic     out_valid,
   output rsp_type  out_rsp
);
   localparam int N = CORDIC_STEPS;

   logic                    v_ff [N+1];
   logic                    fix_ff [N+1];
   logic signed [CRD_W-1:0] x_ff [N+1];
   logic signed [CRD_W-1:0] y_ff [N+1];
   logic signed [ANG_W-1:0] z_ff [N+1];
   cell_type                m_ff [N+1];

   logic signed [CRD_W-1:0] x0, y0;
   logic signed [ANG_W-1:0] z0;
   logic                    fix0;

   // Quadrant and axis handling ahead of the rotations.
   always_comb begin
      y0   = CRD_W'(in_cell.gy);
      x0   = -CRD_W'(in_cell.gx);
      z0   = '0;
      fix0 = 1'b1;
      if (y0 == '0) begin
         z0 = (x0 > 0) ? '0 : DEG180_Q16;
      end else if (x0 == '0) begin
         z0 = (y0 > 0) ? DEG90_Q16 : -DEG90_Q16;
      end else begin
         fix0 = 1'b0;
         if (x0 < 0) begin
            z0 = (y0 > 0) ? DEG180_Q16 : -DEG180_Q16;
            x0 = -x0;
            y0 = -y0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= N; k++) v_ff[k] <= 1'b0;
      end else if (advance) begin
         v_ff[0] <= in_valid;
         for (int k = 0; k < N; k++) v_ff[k+1] <= v_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         x_ff[0]   <= x0;
         y_ff[0]   <= y0;
         z_ff[0]   <= z0;
         fix_ff[0] <= fix0;
         m_ff[0]   <= in_cell;
      end
   end

   for (genvar i = 0; i < N; i++) begin : g_rot
      logic signed [CRD_W-1:0] xn, yn;
      logic signed [ANG_W-1:0] zn, ang;
      always_comb begin
         ang = ANG_W'(atan_q16(i));
         xn  = x_ff[i];
         yn  = y_ff[i];
         zn  = z_ff[i];
         if (!fix_ff[i]) begin
            if (y_ff[i] > 0) begin
               xn = x_ff[i] + (y_ff[i] >>> i);
               yn = y_ff[i] - (x_ff[i] >>> i);
               zn = z_ff[i] + ang;
            end else begin
               xn = x_ff[i] - (y_ff[i] >>> i);
               yn = y_ff[i] + (x_ff[i] >>> i);
               zn = z_ff[i] - ang;
            end
         end
      end
      always_ff @(posedge clock) begin
         if (advance) begin
            x_ff[i+1]   <= xn;
            y_ff[i+1]   <= yn;
            z_ff[i+1]   <= zn;
            fix_ff[i+1] <= fix_ff[i];
            m_ff[i+1]   <= m_ff[i];
         end
      end
   end

   logic signed [ANG_W-1:0] va;
   logic [16:0]             vr;

   always_comb begin
      va = (z_ff[N] > DEG90_Q16) ? DEG450_Q16 - z_ff[N] : DEG90_Q16 - z_ff[N];
      if (va < 0) va = '0;
      vr = 17'((va + ANG_W'(256)) >>> 9);
      if (vr >= ASPECT_WRAP) vr = vr - ASPECT_WRAP;
      out_rsp.row       = m_ff[N].row;
      out_rsp.col       = m_ff[N].col;
      out_rsp.status    = m_ff[N].status;
      out_rsp.aspect    = (m_ff[N].status == STATUS_OK) ? vr[15:0] : 16'd0;
      out_rsp.frame_end = m_ff[N].frame_end;
   end

   assign out_valid = v_ff[N];
endmodule

// ----- rtl/terrain_aspect_3x3_unit.sv -----
// Top level of the 3x3 terrain aspect unit: front, decoupling queue, CORDIC back, result queue.
// Depends on tav_pkg, tav_front, tav_fifo and tav_back.
//
//   Channel   Direction  Handshake          Payload
//   req       in         req_push/req_full  req_elevation
//   rsp       out        rsp_pop/rsp_empty  rsp_out_row, rsp_out_col, rsp_status,
//                                           rsp_aspect, rsp_frame_end
//   csr       in         csr_we             csr_index, csr_wdata
//
// One elevation sample is taken per clock while req_full is low. A result follows the sample
// that completes its window through the middle queue, the one-rotation-per-stage CORDIC
// pipeline and the result queue. Reset is synchronous and clears counters, valid bits and
// queues; the line buffers are not cleared, and what they hold before a raster writes them
// never reaches a result. When the result queue is full the back pipeline holds, the middle
// queue then fills, and req_full rises once it is full.
module terrain_aspect_3x3_unit import tav_pkg::*; #(
   parameter int MAX_COLS     = 2048,
   parameter int CORDIC_STEPS = 20
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_push,
   output logic               req_full,
   input  logic signed [31:0] req_elevation,
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output logic [15:0]        rsp_out_row,
   output logic [10:0]        rsp_out_col,
   output logic [1:0]         rsp_status,
   output logic [15:0]        rsp_aspect,
   output logic               rsp_frame_end,
   input  logic               csr_we,
   input  logic [1:0]         csr_index,
   input  logic [31:0]        csr_wdata
);
   logic     mid_full, mid_empty, front_valid, back_valid, out_full;
   cell_type front_cell, mid_cell;
   rsp_type  back_rsp, head_rsp;

   // The front moves whenever the middle queue has room.
   assign req_full = mid_full;

   tav_front #(.MAX_COLS(MAX_COLS)) u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .in_valid  (req_push),
      .in_elev   (req_elevation),
      .advance   (!mid_full),
      .out_valid (front_valid),
      .out_cell  (front_cell)
   );

   tav_fifo #(.WIDTH($bits(cell_type))) u_mid (
      .clock (clock),
      .reset (reset),
      .push  (front_valid && !mid_full),
      .din   (front_cell),
      .pop   (!out_full),
      .dout  (mid_cell),
      .full  (mid_full),
      .empty (mid_empty)
   );

   // The back moves whenever the result queue has room.
   tav_back #(.CORDIC_STEPS(CORDIC_STEPS)) u_back (
      .clock     (clock),
      .reset     (reset),
      .advance   (!out_full),
      .in_valid  (!mid_empty),
      .in_cell   (mid_cell),
      .out_valid (back_valid),
      .out_rsp   (back_rsp)
   );

   tav_fifo #(.WIDTH($bits(rsp_type))) u_out (
      .clock (clock),
      .reset (reset),
      .push  (back_valid),
      .din   (back_rsp),
      .pop   (rsp_pop),
      .dout  (head_rsp),
      .full  (out_full),
      .empty (rsp_empty)
   );

   assign rsp_out_row   = head_rsp.row;
   assign rsp_out_col   = head_rsp.col;
   assign rsp_status    = head_rsp.status;
   assign rsp_aspect    = head_rsp.aspect;
   assign rsp_frame_end = head_rsp.frame_end;
endmodule

// ----- rtl/tav_checker.sv -----
// Port-level checks for the 3x3 terrain aspect unit, bound to its top level.
// Depends on tav_pkg and terrain_aspect_3x3_unit.
module tav_checker import tav_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        rsp_empty,
   input logic        rsp_pop,
   input logic [1:0]  rsp_status,
   input logic [15:0] rsp_aspect
);
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (rsp_status == STATUS_OK || rsp_status == STATUS_FLAT ||
                      rsp_status == STATUS_NA))
      else $error("invalid status code");

   a_aspect_zero: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_status != STATUS_OK) |-> rsp_aspect == 16'd0)
      else $error("aspect nonzero for flat or no-data cell");

   a_aspect_range: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> rsp_aspect < 16'd46080)
      else $error("aspect out of range");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_aspect)))
      else $error("waiting result changed");
endmodule

bind terrain_aspect_3x3_unit tav_checker u_tav_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_empty  (rsp_empty),
   .rsp_pop    (rsp_pop),
   .rsp_status (rsp_status),
   .rsp_aspect (rsp_aspect)
);
